[rtl/core/tomq_pkg.sv]
// shared types, sizes and codes of the timestamp ordered message queue
package tomq_pkg;

   localparam int QUEUE_DEPTH  = 32;
   localparam int LEDGER_DEPTH = 64;
   localparam int CMDQ_DEPTH   = 2;

   localparam int QAW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCW  = $clog2(QUEUE_DEPTH + 1);
   localparam int LAW  = (LEDGER_DEPTH > 1) ? $clog2(LEDGER_DEPTH) : 1;
   localparam int LFW  = $clog2(LEDGER_DEPTH + 1);
   localparam int SCW  = (LFW > QCW) ? LFW : QCW;
   localparam int CQAW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
   localparam int CQCW = $clog2(CMDQ_DEPTH + 1);

   localparam int ID_W    = 64;
   localparam int REC_W   = 32;
   localparam int SEQ_W   = 64;
   localparam int STAMP_W = 63;
   localparam int KIND_W  = 2;
   localparam int STAT_W  = 4;
   localparam int COUNT_W = 6;
   localparam int SLOT_W  = ID_W + REC_W + SEQ_W + STAMP_W;

   localparam logic [2:0] OP_ENQUEUE         = 3'd0;
   localparam logic [2:0] OP_RETRACT         = 3'd1;
   localparam logic [2:0] OP_RETRACT_PENDING = 3'd2;
   localparam logic [2:0] OP_POP_ELIGIBLE    = 3'd3;
   localparam logic [2:0] OP_EARLIEST_FOR    = 3'd4;
   localparam logic [2:0] OP_DISCARD         = 3'd5;

   localparam logic [STAT_W-1:0] ST_APPLIED       = 4'd0;
   localparam logic [STAT_W-1:0] ST_BAD_ID        = 4'd1;
   localparam logic [STAT_W-1:0] ST_BAD_RECIPIENT = 4'd2;
   localparam logic [STAT_W-1:0] ST_BAD_STAMP     = 4'd3;
   localparam logic [STAT_W-1:0] ST_KIND_MISMATCH = 4'd4;
   localparam logic [STAT_W-1:0] ST_RETRACTED     = 4'd5;
   localparam logic [STAT_W-1:0] ST_DELIVERED     = 4'd6;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND     = 4'd7;
   localparam logic [STAT_W-1:0] ST_FULL          = 4'd8;

   localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ODD  = 2'd3;

   typedef struct packed {
      logic [2:0]         op;
      logic [ID_W-1:0]    id;
      logic [REC_W-1:0]   rec;
      logic [STAMP_W-1:0] stamp;
      logic [KIND_W-1:0]  kind;
      logic               incl;
      logic [STAT_W-1:0]  pre_status;
      logic               go_on;
   } cmd_type;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [REC_W-1:0]   rec;
      logic [SEQ_W-1:0]   seq;
      logic [STAMP_W-1:0] stamp;
   } slot_type;

   typedef struct packed {
      logic               valid;
      logic [STAT_W-1:0]  status;
      logic [COUNT_W-1:0] count;
      logic               value_present;
      logic [ID_W-1:0]    id;
      logic [REC_W-1:0]   rec;
      logic [SEQ_W-1:0]   seq;
      logic [STAMP_W-1:0] stamp;
      logic               last;
   } rsp_type;

   // a kind code that differs from the bound one, the none code or an odd code, is a mismatch
   function automatic logic kind_bad(logic [KIND_W-1:0] kind, logic [KIND_W-1:0] bound);
      return (kind != bound) || (kind == KIND_NONE) || (kind == KIND_ODD);
   endfunction

endpackage

[rtl/core/tomq_ram.sv]
// generic single write, single read ram with registered read data
module tomq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/tomq_front.sv]
// front end: takes commands, prechecks them and queues them for the back end
module tomq_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [2:0]                   op,
   input  logic [tomq_pkg::ID_W-1:0]    message_id,
   input  logic [tomq_pkg::REC_W-1:0]   recipient,
   input  logic [tomq_pkg::STAMP_W-1:0] stamp,
   input  logic [tomq_pkg::KIND_W-1:0]  stamp_kind,
   input  logic                         inclusive,
   input  logic [tomq_pkg::KIND_W-1:0]  cfg_kind,
   input  logic                         pop,
   output logic                         cmd_avail,
   output tomq_pkg::cmd_type            cmd
);

   tomq_pkg::cmd_type               q_ff [tomq_pkg::CMDQ_DEPTH];
   logic [tomq_pkg::CQAW-1:0]       wp_ff, wp_in, rp_ff, rp_in;
   logic [tomq_pkg::CQCW-1:0]       cnt_ff, cnt_in;
   tomq_pkg::cmd_type               cls;
   logic                            push;
   logic                            id_zero, rec_zero, stamp_bad, cfg_bad;

   assign busy      = (cnt_ff == tomq_pkg::CQCW'(tomq_pkg::CMDQ_DEPTH));
   assign push      = start && !busy;
   assign cmd_avail = (cnt_ff != '0);
   assign cmd       = q_ff[rp_ff];

   assign id_zero   = (message_id == '0);
   assign rec_zero  = (recipient == '0);
   assign stamp_bad = (stamp == '0) || (stamp == '1);
   assign cfg_bad   = (cfg_kind != tomq_pkg::KIND_NONE) &&
                      tomq_pkg::kind_bad(stamp_kind, cfg_kind);

   // checks that need only the command and the bound kind
   always_comb begin
      cls.op         = op;
      cls.id         = message_id;
      cls.rec        = recipient;
      cls.stamp      = stamp;
      cls.kind       = stamp_kind;
      cls.incl       = inclusive;
      cls.pre_status = tomq_pkg::ST_APPLIED;
      cls.go_on      = 1'b0;
      case (op)
         tomq_pkg::OP_ENQUEUE: begin
            if (id_zero)        cls.pre_status = tomq_pkg::ST_BAD_ID;
            else if (rec_zero)  cls.pre_status = tomq_pkg::ST_BAD_RECIPIENT;
            else if (stamp_bad) cls.pre_status = tomq_pkg::ST_BAD_STAMP;
            else if (cfg_bad)   cls.pre_status = tomq_pkg::ST_KIND_MISMATCH;
            else                cls.go_on      = 1'b1;
         end
         tomq_pkg::OP_RETRACT, tomq_pkg::OP_RETRACT_PENDING: begin
            if (id_zero) cls.pre_status = tomq_pkg::ST_BAD_ID;
            else         cls.go_on      = 1'b1;
         end
         tomq_pkg::OP_POP_ELIGIBLE: begin
            if (rec_zero)     cls.pre_status = tomq_pkg::ST_BAD_RECIPIENT;
            else if (cfg_bad) cls.pre_status = tomq_pkg::ST_KIND_MISMATCH;
            else              cls.go_on      = 1'b1;
         end
         tomq_pkg::OP_EARLIEST_FOR, tomq_pkg::OP_DISCARD: begin
            if (rec_zero) cls.pre_status = tomq_pkg::ST_BAD_RECIPIENT;
            else          cls.go_on      = 1'b1;
         end
         default: begin
            cls.go_on = 1'b0;
         end
      endcase
   end

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wp_in = (wp_ff == tomq_pkg::CQAW'(tomq_pkg::CMDQ_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
      end
      if (pop) begin
         rp_in = (rp_ff == tomq_pkg::CQAW'(tomq_pkg::CMDQ_DEPTH - 1)) ? '0 : rp_ff + 1'b1;
      end
      if (push && !pop)      cnt_in = cnt_ff + 1'b1;
      else if (!push && pop) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wp_ff] <= cls;
      end
   end

endmodule

[rtl/core/tomq_back.sv]
// back end: scans the store and the ledgers and produces the results
module tomq_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [tomq_pkg::KIND_W-1:0] cfg_kind,
   input  logic                        cmd_avail,
   input  tomq_pkg::cmd_type           cmd,
   output logic                        cmd_pop,
   output tomq_pkg::rsp_type           rsp
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_LED  = 4'b0010,
      S_SLOT = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type                      state_ff, state_in;
   tomq_pkg::cmd_type              cmd_ff, cmd_in;
   logic [tomq_pkg::SCW-1:0]       idx_ff, idx_in;
   logic                           p_ff, p_in;
   logic [tomq_pkg::SCW-1:0]       p_idx_ff, p_idx_in;
   logic                           rhit_ff, rhit_in, dhit_ff, dhit_in;
   logic [tomq_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic                           found_ff, found_in;
   logic [tomq_pkg::QAW-1:0]       best_idx_ff, best_idx_in;
   tomq_pkg::slot_type             best_ff, best_in;
   logic                           held_ff, held_in;
   tomq_pkg::slot_type             held_msg_ff, held_msg_in;
   logic [tomq_pkg::QUEUE_DEPTH-1:0] valid_ff, valid_in;
   logic [tomq_pkg::LFW-1:0]       rfill_ff, rfill_in, dfill_ff, dfill_in;
   logic [tomq_pkg::LAW-1:0]       rhead_ff, rhead_in, dhead_ff, dhead_in;
   logic [tomq_pkg::SEQ_W-1:0]     nseq_ff, nseq_in;
   logic [tomq_pkg::KIND_W-1:0]    adm_ff, adm_in;
   tomq_pkg::rsp_type              rsp_ff, rsp_in;

   logic                           r_add, d_add;
   logic [tomq_pkg::ID_W-1:0]      d_add_id;
   logic [tomq_pkg::LAW-1:0]       r_waddr, d_waddr;
   logic [tomq_pkg::ID_W-1:0]      r_rdata, d_rdata;
   logic                           s_we;
   logic [tomq_pkg::QAW-1:0]       s_waddr;
   tomq_pkg::slot_type             s_wdata, s_rdata;
   logic [tomq_pkg::SLOT_W-1:0]    s_rraw;
   logic [tomq_pkg::LFW-1:0]       lim;
   logic                           free_any;
   logic [tomq_pkg::QAW-1:0]       free_idx;
   logic                           eligible, better;
   logic [tomq_pkg::QAW-1:0]       p_sidx;

   // ledgers and slot store
   tomq_ram #(.WIDTH(tomq_pkg::ID_W), .DEPTH(tomq_pkg::LEDGER_DEPTH)) u_rled (
      .clock(clock), .wr_en(r_add), .wr_addr(r_waddr), .wr_data(cmd_ff.id),
      .rd_addr(idx_ff[tomq_pkg::LAW-1:0]), .rd_data(r_rdata));

   tomq_ram #(.WIDTH(tomq_pkg::ID_W), .DEPTH(tomq_pkg::LEDGER_DEPTH)) u_dled (
      .clock(clock), .wr_en(d_add), .wr_addr(d_waddr), .wr_data(d_add_id),
      .rd_addr(idx_ff[tomq_pkg::LAW-1:0]), .rd_data(d_rdata));

   tomq_ram #(.WIDTH(tomq_pkg::SLOT_W), .DEPTH(tomq_pkg::QUEUE_DEPTH)) u_slot (
      .clock(clock), .wr_en(s_we), .wr_addr(s_waddr), .wr_data(s_wdata),
      .rd_addr(idx_ff[tomq_pkg::QAW-1:0]), .rd_data(s_rraw));

   assign s_rdata = tomq_pkg::slot_type'(s_rraw);
   assign rsp     = rsp_ff;
   assign p_sidx  = p_idx_ff[tomq_pkg::QAW-1:0];
   assign lim     = (rfill_ff > dfill_ff) ? rfill_ff : dfill_ff;

   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = tomq_pkg::QUEUE_DEPTH - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = tomq_pkg::QAW'(i);
         end
      end
   end

   // pop candidate test and timestamp-then-sequence order; earliest compares timestamps only
   always_comb begin
      eligible = valid_ff[p_sidx] && (s_rdata.rec == cmd_ff.rec);
      if (cmd_ff.op == tomq_pkg::OP_POP_ELIGIBLE) begin
         eligible = eligible && ((s_rdata.stamp < cmd_ff.stamp) ||
                                 (cmd_ff.incl && (s_rdata.stamp == cmd_ff.stamp)));
         better   = !found_ff || (s_rdata.stamp < best_ff.stamp) ||
                    ((s_rdata.stamp == best_ff.stamp) && (s_rdata.seq < best_ff.seq));
      end else begin
         better   = !found_ff || (s_rdata.stamp < best_ff.stamp);
      end
   end

   always_comb begin
      r_waddr  = (rfill_ff < tomq_pkg::LFW'(tomq_pkg::LEDGER_DEPTH)) ?
                 rfill_ff[tomq_pkg::LAW-1:0] : rhead_ff;
      d_waddr  = (dfill_ff < tomq_pkg::LFW'(tomq_pkg::LEDGER_DEPTH)) ?
                 dfill_ff[tomq_pkg::LAW-1:0] : dhead_ff;
      d_add_id = best_ff.id;
   end

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      idx_in      = idx_ff;
      p_in        = 1'b0;
      p_idx_in    = idx_ff;
      rhit_in     = rhit_ff;
      dhit_in     = dhit_ff;
      count_in    = count_ff;
      found_in    = found_ff;
      best_idx_in = best_idx_ff;
      best_in     = best_ff;
      held_in     = held_ff;
      held_msg_in = held_msg_ff;
      valid_in    = valid_ff;
      nseq_in     = nseq_ff;
      adm_in      = adm_ff;
      rsp_in      = '0;
      cmd_pop     = 1'b0;
      r_add       = 1'b0;
      d_add       = 1'b0;
      s_we        = 1'b0;
      s_waddr     = free_idx;
      s_wdata.id    = cmd_ff.id;
      s_wdata.rec   = cmd_ff.rec;
      s_wdata.seq   = nseq_ff;
      s_wdata.stamp = cmd_ff.stamp;

      case (state_ff)
         S_IDLE: begin
            if (cmd_avail) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd;
               idx_in   = '0;
               rhit_in  = 1'b0;
               dhit_in  = 1'b0;
               count_in = '0;
               found_in = 1'b0;
               held_in  = 1'b0;
               if (!cmd.go_on) begin
                  rsp_in.valid  = 1'b1;
                  rsp_in.status = cmd.pre_status;
                  rsp_in.last   = 1'b1;
               end else if (cmd.op == tomq_pkg::OP_ENQUEUE ||
                            cmd.op == tomq_pkg::OP_RETRACT ||
                            cmd.op == tomq_pkg::OP_RETRACT_PENDING) begin
                  state_in = S_LED;
               end else begin
                  state_in = S_SLOT;
               end
            end
         end

         S_LED: begin
            if (p_ff) begin
               if (p_idx_ff < tomq_pkg::SCW'(rfill_ff) && r_rdata == cmd_ff.id) rhit_in = 1'b1;
               if (p_idx_ff < tomq_pkg::SCW'(dfill_ff) && d_rdata == cmd_ff.id) dhit_in = 1'b1;
            end
            if (idx_ff < tomq_pkg::SCW'(lim)) begin
               p_in   = 1'b1;
               idx_in = idx_ff + 1'b1;
            end else if (!p_ff) begin
               idx_in   = '0;
               state_in = S_IDLE;
               rsp_in.valid = 1'b1;
               rsp_in.last  = 1'b1;
               case (cmd_ff.op)
                  tomq_pkg::OP_ENQUEUE: begin
                     if (rhit_ff)              rsp_in.status = tomq_pkg::ST_RETRACTED;
                     else if (dhit_ff)         rsp_in.status = tomq_pkg::ST_DELIVERED;
                     else if (nseq_ff == '0)   rsp_in.status = tomq_pkg::ST_BAD_ID;
                     else if (cfg_kind == tomq_pkg::KIND_NONE && adm_ff != tomq_pkg::KIND_NONE &&
                              tomq_pkg::kind_bad(cmd_ff.kind, adm_ff))
                        rsp_in.status = tomq_pkg::ST_KIND_MISMATCH;
                     else if (!free_any)       rsp_in.status = tomq_pkg::ST_FULL;
                     else begin
                        rsp_in.status      = tomq_pkg::ST_APPLIED;
                        s_we               = 1'b1;
                        valid_in[free_idx] = 1'b1;
                        nseq_in            = nseq_ff + 1'b1;
                        if (cfg_kind == tomq_pkg::KIND_NONE && adm_ff == tomq_pkg::KIND_NONE)
                           adm_in = cmd_ff.kind;
                     end
                  end
                  tomq_pkg::OP_RETRACT: begin
                     if (dhit_ff)      rsp_in.status = tomq_pkg::ST_DELIVERED;
                     else if (rhit_ff) rsp_in.status = tomq_pkg::ST_RETRACTED;
                     else begin
                        rsp_in.valid = 1'b0;
                        state_in     = S_SLOT;
                     end
                  end
                  default: begin
                     if (rhit_ff) rsp_in.status = tomq_pkg::ST_RETRACTED;
                     else begin
                        rsp_in.valid = 1'b0;
                        state_in     = S_SLOT;
                     end
                  end
               endcase
            end
         end

         S_SLOT: begin
            if (p_ff) begin
               case (cmd_ff.op)
                  tomq_pkg::OP_RETRACT, tomq_pkg::OP_RETRACT_PENDING: begin
                     if (valid_ff[p_sidx] && s_rdata.id == cmd_ff.id) begin
                        valid_in[p_sidx] = 1'b0;
                        count_in         = count_ff + 1'b1;
                     end
                  end
                  tomq_pkg::OP_DISCARD: begin
                     if (valid_ff[p_sidx] && s_rdata.rec == cmd_ff.rec) begin
                        valid_in[p_sidx] = 1'b0;
                        count_in         = count_ff + 1'b1;
                     end
                  end
                  default: begin
                     if (eligible && better) begin
                        found_in    = 1'b1;
                        best_idx_in = p_sidx;
                        best_in     = s_rdata;
                     end
                  end
               endcase
            end
            if (idx_ff < tomq_pkg::SCW'(tomq_pkg::QUEUE_DEPTH)) begin
               p_in   = 1'b1;
               idx_in = idx_ff + 1'b1;
            end else if (!p_ff) begin
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            idx_in       = '0;
            state_in     = S_IDLE;
            rsp_in.valid = 1'b1;
            rsp_in.last  = 1'b1;
            case (cmd_ff.op)
               tomq_pkg::OP_RETRACT, tomq_pkg::OP_RETRACT_PENDING: begin
                  if (count_ff != '0 ||
                      (cmd_ff.op == tomq_pkg::OP_RETRACT_PENDING && dhit_ff)) begin
                     r_add        = 1'b1;
                     rsp_in.count = count_ff;
                  end else begin
                     rsp_in.status = tomq_pkg::ST_NOT_FOUND;
                  end
               end
               tomq_pkg::OP_DISCARD: begin
                  rsp_in.count = count_ff;
               end
               tomq_pkg::OP_EARLIEST_FOR: begin
                  if (found_ff) begin
                     rsp_in.value_present = 1'b1;
                     rsp_in.stamp         = best_ff.stamp;
                  end else begin
                     rsp_in.status = tomq_pkg::ST_NOT_FOUND;
                  end
               end
               default: begin
                  // pop: the previous pick goes out once the next scan is known
                  if (found_ff) begin
                     valid_in[best_idx_ff] = 1'b0;
                     d_add       = 1'b1;
                     held_in     = 1'b1;
                     held_msg_in = best_ff;
                     found_in    = 1'b0;
                     state_in    = S_SLOT;
                     rsp_in.valid = held_ff;
                     rsp_in.last  = 1'b0;
                  end
                  if (held_ff) begin
                     rsp_in.value_present = 1'b1;
                     rsp_in.id            = held_msg_ff.id;
                     rsp_in.rec           = held_msg_ff.rec;
                     rsp_in.seq           = held_msg_ff.seq;
                     rsp_in.stamp         = held_msg_ff.stamp;
                  end
               end
            endcase
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rfill_in = rfill_ff;
      rhead_in = rhead_ff;
      dfill_in = dfill_ff;
      dhead_in = dhead_ff;
      if (r_add) begin
         if (rfill_ff < tomq_pkg::LFW'(tomq_pkg::LEDGER_DEPTH)) rfill_in = rfill_ff + 1'b1;
         else rhead_in = (rhead_ff == tomq_pkg::LAW'(tomq_pkg::LEDGER_DEPTH - 1)) ?
                         '0 : rhead_ff + 1'b1;
      end
      if (d_add) begin
         if (dfill_ff < tomq_pkg::LFW'(tomq_pkg::LEDGER_DEPTH)) dfill_in = dfill_ff + 1'b1;
         else dhead_in = (dhead_ff == tomq_pkg::LAW'(tomq_pkg::LEDGER_DEPTH - 1)) ?
                         '0 : dhead_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         p_ff         <= 1'b0;
         valid_ff     <= '0;
         rfill_ff     <= '0;
         dfill_ff     <= '0;
         rhead_ff     <= '0;
         dhead_ff     <= '0;
         nseq_ff      <= tomq_pkg::SEQ_W'(1);
         adm_ff       <= tomq_pkg::KIND_NONE;
         rsp_ff.valid <= 1'b0;
         held_ff      <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         p_ff         <= p_in;
         valid_ff     <= valid_in;
         rfill_ff     <= rfill_in;
         dfill_ff     <= dfill_in;
         rhead_ff     <= rhead_in;
         dhead_ff     <= dhead_in;
         nseq_ff      <= nseq_in;
         adm_ff       <= adm_in;
         rsp_ff.valid <= rsp_in.valid;
         held_ff      <= held_in;
         found_ff     <= found_in;
      end
      cmd_ff               <= cmd_in;
      p_idx_ff             <= p_idx_in;
      rhit_ff              <= rhit_in;
      dhit_ff              <= dhit_in;
      count_ff             <= count_in;
      best_idx_ff          <= best_idx_in;
      best_ff              <= best_in;
      held_msg_ff          <= held_msg_in;
      rsp_ff.status        <= rsp_in.status;
      rsp_ff.count         <= rsp_in.count;
      rsp_ff.value_present <= rsp_in.value_present;
      rsp_ff.id            <= rsp_in.id;
      rsp_ff.rec           <= rsp_in.rec;
      rsp_ff.seq           <= rsp_in.seq;
      rsp_ff.stamp         <= rsp_in.stamp;
      rsp_ff.last          <= rsp_in.last;
   end

`ifndef NO_ASSERTIONS
   a_rfill: assert property (@(posedge clock) disable iff (reset)
      rfill_ff <= tomq_pkg::LFW'(tomq_pkg::LEDGER_DEPTH))
      else $error("retracted fill beyond depth");
   a_scan: assert property (@(posedge clock) disable iff (reset)
      p_ff |-> ($past(state_ff) == S_LED || $past(state_ff) == S_SLOT))
      else $error("compare without a scan read");
   a_mid: assert property (@(posedge clock) disable iff (reset)
      (rsp_ff.valid && !rsp_ff.last) |-> (state_ff == S_SLOT && held_ff))
      else $error("non-final result outside a pop scan");
   a_pop: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (state_ff == S_IDLE && cmd_avail))
      else $error("command taken while busy");
`endif

endmodule

[rtl/core/timestamp_ordered_message_queue.sv]
// top level of the timestamp ordered message queue
//
// a command is a transfer at a clock edge with start high and busy low; a
// two-entry command queue lets the front take up to two commands while the
// back end works. results come out one cycle each with rsp_valid high and
// cannot be held off; rsp_last marks the final result of a command. every
// command runs on one sequencer that reads one slot or one ledger row per
// cycle through registered ram ports: precheck rejects need no scan, enqueue
// scans the ledgers, retract the ledgers and then, unless a ledger hit settles
// it, the store, earliest and discard the store, and pop the store once per
// delivered message plus one final scan. the bound time kind is written on the
// csr channel, which is always ready; the user must write it only while no
// command is in flight, as the block itself does not enforce it
module timestamp_ordered_message_queue (
   input  logic                         clock,
   input  logic                         reset,
   // command channel
   input  logic                         start,
   output logic                         busy,
   input  logic [2:0]                   req_op,
   input  logic [tomq_pkg::ID_W-1:0]    req_message_id,
   input  logic [tomq_pkg::REC_W-1:0]   req_recipient,
   input  logic [tomq_pkg::STAMP_W-1:0] req_stamp,
   input  logic [tomq_pkg::KIND_W-1:0]  req_stamp_kind,
   input  logic                         req_inclusive,
   // configuration write
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [tomq_pkg::KIND_W-1:0]  csr_data,
   // results
   output logic                         rsp_valid,
   output logic [tomq_pkg::STAT_W-1:0]  rsp_status,
   output logic [tomq_pkg::COUNT_W-1:0] rsp_count,
   output logic                         rsp_value_present,
   output logic [tomq_pkg::ID_W-1:0]    rsp_out_id,
   output logic [tomq_pkg::REC_W-1:0]   rsp_out_recipient,
   output logic [tomq_pkg::SEQ_W-1:0]   rsp_out_sequence,
   output logic [tomq_pkg::STAMP_W-1:0] rsp_out_stamp,
   output logic                         rsp_last
);

   logic [tomq_pkg::KIND_W-1:0] kind_ff;
   logic                        cmd_avail, cmd_pop;
   tomq_pkg::cmd_type           cmd;
   tomq_pkg::rsp_type           rsp;

   // configured kind register, one transfer per cycle
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= tomq_pkg::KIND_NONE;
      end else if (csr_valid) begin
         kind_ff <= csr_data;
      end
   end

   // front: precheck and command queue
   tomq_front u_front (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .op(req_op), .message_id(req_message_id), .recipient(req_recipient),
      .stamp(req_stamp), .stamp_kind(req_stamp_kind), .inclusive(req_inclusive),
      .cfg_kind(kind_ff), .pop(cmd_pop), .cmd_avail(cmd_avail), .cmd(cmd));

   // back: store and ledger scans
   tomq_back u_back (
      .clock(clock), .reset(reset), .cfg_kind(kind_ff),
      .cmd_avail(cmd_avail), .cmd(cmd), .cmd_pop(cmd_pop), .rsp(rsp));

   assign rsp_valid         = rsp.valid;
   assign rsp_status        = rsp.status;
   assign rsp_count         = rsp.count;
   assign rsp_value_present = rsp.value_present;
   assign rsp_out_id        = rsp.id;
   assign rsp_out_recipient = rsp.rec;
   assign rsp_out_sequence  = rsp.seq;
   assign rsp_out_stamp     = rsp.stamp;
   assign rsp_last          = rsp.last;

endmodule
